@@ rtl/rectangle_raster_canvas_core_assert.svh @@
// assertion macros for the canvas rtl
`ifndef RECTANGLE_RASTER_CANVAS_CORE_ASSERT_SVH
`define RECTANGLE_RASTER_CANVAS_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define RRC_ASSERT_IMPLY(name, clock, rstn, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("rrc assertion failed");
// next-cycle implication
`define RRC_ASSERT_NEXT(name, clock, rstn, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("rrc assertion failed");
`else
`define RRC_ASSERT_IMPLY(name, clock, rstn, ante, cons)
`define RRC_ASSERT_NEXT(name, clock, rstn, ante, cons)
`endif

`endif

@@ rtl/rrc_pkg.sv @@
`default_nettype none

package rrc_pkg;

	localparam int OPC_W   = 2;
	localparam int FLAG_W  = 1;
	localparam int EDGE_W  = 20;
	localparam int SIZE_W  = 19;
	localparam int CHAR_W  = 8;
	localparam int RC_W    = 8;
	localparam int ST_W    = 2;
	localparam int CFG_W   = 9;
	localparam int CFGI_W  = 2;

	typedef enum logic [OPC_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_DRAW  = 2'd1,
		OP_READ  = 2'd2
	} opcode_t;

	typedef enum logic [CFGI_W-1:0] {
		REG_CANVAS_WIDTH  = 2'd0,
		REG_CANVAS_HEIGHT = 2'd1,
		REG_BG_CHAR       = 2'd2
	} cfg_reg_t;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_SMALL   = 2'd1;
	localparam logic [ST_W-1:0] ST_OUTSIDE = 2'd2;

	localparam logic [CHAR_W-1:0] BG_CHAR_RESET = 8'd32;

	// what the back end has to do with a command
	typedef enum logic [1:0] {
		KIND_NOP   = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_DRAW  = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		BK_IDLE  = 3'd0,
		BK_SETUP = 3'd1,
		BK_SWEEP = 3'd2,
		BK_READ  = 3'd3,
		BK_DONE  = 3'd4
	} back_state_t;

	typedef struct packed {
		kind_t                     kind;
		logic                      filled_mode;
		logic signed [EDGE_W-1:0]  rect_left;
		logic signed [EDGE_W-1:0]  rect_top;
		logic [SIZE_W-1:0]         rect_width;
		logic [SIZE_W-1:0]         rect_height;
		logic [CHAR_W-1:0]         paint_char;
		logic [RC_W-1:0]           read_col;
		logic [RC_W-1:0]           read_row;
		logic [ST_W-1:0]           status;
	} cmd_t;

	typedef struct packed {
		logic [CHAR_W-1:0] cell_char;
		logic [ST_W-1:0]   status;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/rectangle_raster_canvas_core.sv @@
// flow: the front registers each item; the back end pops one command at a time and runs
//   SETUP (draw only), SWEEP (clear, draw) or READ, or only DONE for a rejected or unknown
//   item, and DONE pushes the result; one cell per cycle, up to 65536 at 256 by 256
// a two-entry command queue and a two-entry result queue let either side stall alone
// reset: asynchronous, active low; clears control state, sets the canvas to 1 by 1 and
//   the background to a space; cell contents stay undefined until a clear or a draw writes them
`default_nettype none
`include "rectangle_raster_canvas_core_assert.svh"

module rectangle_raster_canvas_core #(
	parameter int MAX_SIDE  = 256,
	parameter int FRAC_BITS = 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration write port
	input  wire logic                               cfg_write,
	input  wire logic [rrc_pkg::CFGI_W-1:0]         cfg_index,
	input  wire logic [rrc_pkg::CFG_W-1:0]          cfg_data,
	// item side
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic [rrc_pkg::OPC_W-1:0]          opcode,
	input  wire logic                               filled_mode,
	input  wire logic signed [rrc_pkg::EDGE_W-1:0]  rect_left,
	input  wire logic signed [rrc_pkg::EDGE_W-1:0]  rect_top,
	input  wire logic [rrc_pkg::SIZE_W-1:0]         rect_width,
	input  wire logic [rrc_pkg::SIZE_W-1:0]         rect_height,
	input  wire logic [rrc_pkg::CHAR_W-1:0]         paint_char,
	input  wire logic [rrc_pkg::RC_W-1:0]           read_col,
	input  wire logic [rrc_pkg::RC_W-1:0]           read_row,
	// result side
	output logic                                    empty,
	input  wire logic                               pop,
	output logic [rrc_pkg::CHAR_W-1:0]              cell_char,
	output logic [rrc_pkg::ST_W-1:0]                status
);

	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int QD = 2;

	// configuration registers
	logic [rrc_pkg::CFG_W-1:0]  canvas_width_q;
	logic [rrc_pkg::CFG_W-1:0]  canvas_height_q;
	logic [rrc_pkg::CHAR_W-1:0] bg_char_q;

	// canvas size clamped into 1..MAX_SIDE
	logic [SW-1:0] cw;
	logic [SW-1:0] ch;

	// front to back command queue
	logic          cmd_push;
	logic          cmd_full;
	logic          cmd_pop;
	logic          cmd_empty;
	rrc_pkg::cmd_t cmd_in;
	rrc_pkg::cmd_t cmd_head;

	// back end to result queue
	logic          res_push;
	logic          res_full;
	rrc_pkg::res_t res_in;
	rrc_pkg::res_t res_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_width_q  <= rrc_pkg::CFG_W'(1);
			canvas_height_q <= rrc_pkg::CFG_W'(1);
			bg_char_q       <= rrc_pkg::BG_CHAR_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				rrc_pkg::REG_CANVAS_WIDTH: begin
					canvas_width_q <= cfg_data;
				end
				rrc_pkg::REG_CANVAS_HEIGHT: begin
					canvas_height_q <= cfg_data;
				end
				rrc_pkg::REG_BG_CHAR: begin
					bg_char_q <= cfg_data[rrc_pkg::CHAR_W-1:0];
				end
				default: begin
					// writes past the register list are dropped
				end
			endcase
		end
	end

	// zero counts as one, anything past the canvas store as its full side
	always_comb begin
		if (canvas_width_q == '0) begin
			cw = SW'(1);
		end else if (int'(canvas_width_q) > MAX_SIDE) begin
			cw = SW'(MAX_SIDE);
		end else begin
			cw = SW'(canvas_width_q);
		end
		if (canvas_height_q == '0) begin
			ch = SW'(1);
		end else if (int'(canvas_height_q) > MAX_SIDE) begin
			ch = SW'(MAX_SIDE);
		end else begin
			ch = SW'(canvas_height_q);
		end
	end

	// front: takes items, rejects small rectangles and reads off the canvas
	rrc_front #(
		.MAX_SIDE  (MAX_SIDE),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.filled_mode (filled_mode),
		.rect_left   (rect_left),
		.rect_top    (rect_top),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.paint_char  (paint_char),
		.read_col    (read_col),
		.read_row    (read_row),
		.cw          (cw),
		.ch          (ch),
		.cmd_push    (cmd_push),
		.cmd_data    (cmd_in),
		.cmd_full    (cmd_full)
	);

	rrc_fifo #(
		.WIDTH ($bits(rrc_pkg::cmd_t)),
		.DEPTH (QD)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty)
	);

	// back: sweeps the canvas for clear and draw, reads single cells
	rrc_back #(
		.MAX_SIDE  (MAX_SIDE),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_head  (cmd_head),
		.cmd_pop   (cmd_pop),
		.cw        (cw),
		.ch        (ch),
		.bg_char   (bg_char_q),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_in)
	);

	// result queue decouples the back end from a stalled consumer
	rrc_fifo #(
		.WIDTH ($bits(rrc_pkg::res_t)),
		.DEPTH (QD)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty)
	);

	assign cell_char = res_head.cell_char;
	assign status    = res_head.status;

	// back end only takes a command that is there
	`RRC_ASSERT_IMPLY(a_cmd_pop_nonempty, clk, arst_n, cmd_pop, !cmd_empty)
	// a finished command never overruns the result queue
	`RRC_ASSERT_IMPLY(a_res_push_room, clk, arst_n, res_push, !res_full)
	// a pushed result is visible the next cycle
	`RRC_ASSERT_NEXT(a_res_visible, clk, arst_n, res_push, !empty)
	// error results carry no character
	`RRC_ASSERT_IMPLY(a_err_char_zero, clk, arst_n, !empty && (status != rrc_pkg::ST_OK), cell_char == '0)

endmodule

`default_nettype wire

@@ rtl/rrc_fifo.sv @@
`default_nettype none

module rrc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNTW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: begin
					cnt_q <= cnt_q + 1'b1;
				end
				2'b01: begin
					cnt_q <= cnt_q - 1'b1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

@@ rtl/rrc_front.sv @@
`default_nettype none

module rrc_front #(
	parameter int MAX_SIDE  = 256,
	parameter int FRAC_BITS = 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic [rrc_pkg::OPC_W-1:0]          opcode,
	input  wire logic                               filled_mode,
	input  wire logic signed [rrc_pkg::EDGE_W-1:0]  rect_left,
	input  wire logic signed [rrc_pkg::EDGE_W-1:0]  rect_top,
	input  wire logic [rrc_pkg::SIZE_W-1:0]         rect_width,
	input  wire logic [rrc_pkg::SIZE_W-1:0]         rect_height,
	input  wire logic [rrc_pkg::CHAR_W-1:0]         paint_char,
	input  wire logic [rrc_pkg::RC_W-1:0]           read_col,
	input  wire logic [rrc_pkg::RC_W-1:0]           read_row,
	input  wire logic [$clog2(MAX_SIDE+1)-1:0]      cw,
	input  wire logic [$clog2(MAX_SIDE+1)-1:0]      ch,
	output logic                                    cmd_push,
	output rrc_pkg::cmd_t                           cmd_data,
	input  wire logic                               cmd_full
);

	localparam int ONE_I = 1 << FRAC_BITS;

	logic          valid_s1;
	rrc_pkg::cmd_t cmd_s1;
	rrc_pkg::cmd_t cmd_next;
	logic          accept;
	logic          too_small;
	logic          off_canvas;

	assign full     = valid_s1 && cmd_full;
	assign accept   = push && !full;
	assign cmd_push = valid_s1 && !cmd_full;
	assign cmd_data = cmd_s1;

	assign too_small  = (int'(rect_width) < ONE_I) || (int'(rect_height) < ONE_I);
	assign off_canvas = (int'(read_col) >= int'(cw)) || (int'(read_row) >= int'(ch));

	// sort the item into a back end command
	always_comb begin
		cmd_next.kind        = rrc_pkg::KIND_NOP;
		cmd_next.filled_mode = filled_mode;
		cmd_next.rect_left   = rect_left;
		cmd_next.rect_top    = rect_top;
		cmd_next.rect_width  = rect_width;
		cmd_next.rect_height = rect_height;
		cmd_next.paint_char  = paint_char;
		cmd_next.read_col    = read_col;
		cmd_next.read_row    = read_row;
		cmd_next.status      = rrc_pkg::ST_OK;
		case (opcode)
			rrc_pkg::OP_CLEAR: begin
				cmd_next.kind = rrc_pkg::KIND_CLEAR;
			end
			rrc_pkg::OP_DRAW: begin
				if (too_small) begin
					cmd_next.status = rrc_pkg::ST_SMALL;
				end else begin
					cmd_next.kind = rrc_pkg::KIND_DRAW;
				end
			end
			rrc_pkg::OP_READ: begin
				if (off_canvas) begin
					cmd_next.status = rrc_pkg::ST_OUTSIDE;
				end else begin
					cmd_next.kind = rrc_pkg::KIND_READ;
				end
			end
			default: begin
				cmd_next.kind = rrc_pkg::KIND_NOP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (cmd_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_next;
		end
	end

endmodule

`default_nettype wire

@@ rtl/rrc_back.sv @@
`default_nettype none

module rrc_back #(
	parameter int MAX_SIDE  = 256,
	parameter int FRAC_BITS = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cmd_empty,
	input  wire rrc_pkg::cmd_t                  cmd_head,
	output logic                                cmd_pop,
	input  wire logic [$clog2(MAX_SIDE+1)-1:0]  cw,
	input  wire logic [$clog2(MAX_SIDE+1)-1:0]  ch,
	input  wire logic [rrc_pkg::CHAR_W-1:0]     bg_char,
	input  wire logic                           res_full,
	output logic                                res_push,
	output rrc_pkg::res_t                       res_data
);

	localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int SW    = $clog2(MAX_SIDE + 1);
	localparam int DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EW    = (CW + FRAC_BITS + 2 > 23) ? CW + FRAC_BITS + 2 : 23;
	localparam logic signed [EW-1:0] ONE = {{(EW-1){1'b0}}, 1'b1} << FRAC_BITS;

	rrc_pkg::back_state_t state_q;
	rrc_pkg::back_state_t state_d;
	rrc_pkg::cmd_t        cmd_q;

	logic [CW-1:0] c_q;
	logic [CW-1:0] r_q;
	logic          last_col;
	logic          last_row;

	// edge thresholds: outer bounds and the inner border lines
	logic signed [EW-1:0] xl_q, xr_q, xli_q, xri_q;
	logic signed [EW-1:0] yt_q, yb_q, yti_q, ybi_q;
	logic signed [EW-1:0] l_ext, t_ext, w_ext, h_ext;
	logic signed [EW-1:0] px, py;
	logic                 in_rect;
	logic                 border;
	logic                 hit;

	logic [rrc_pkg::CHAR_W-1:0] cell_mem_q [DEPTH];
	logic [rrc_pkg::CHAR_W-1:0] rd_q;
	logic                       mem_we;
	logic                       mem_re;
	logic [AW-1:0]              waddr;
	logic [AW-1:0]              raddr;
	logic [rrc_pkg::CHAR_W-1:0] wdata;

	assign l_ext = {{(EW-rrc_pkg::EDGE_W){cmd_q.rect_left[rrc_pkg::EDGE_W-1]}}, cmd_q.rect_left};
	assign t_ext = {{(EW-rrc_pkg::EDGE_W){cmd_q.rect_top[rrc_pkg::EDGE_W-1]}}, cmd_q.rect_top};
	assign w_ext = {{(EW-rrc_pkg::SIZE_W){1'b0}}, cmd_q.rect_width};
	assign h_ext = {{(EW-rrc_pkg::SIZE_W){1'b0}}, cmd_q.rect_height};

	assign px = {{(EW-CW-FRAC_BITS){1'b0}}, c_q, {FRAC_BITS{1'b0}}};
	assign py = {{(EW-CW-FRAC_BITS){1'b0}}, r_q, {FRAC_BITS{1'b0}}};

	assign in_rect = (px >= xl_q) && (px <= xr_q) && (py >= yt_q) && (py <= yb_q);
	assign border  = (px < xli_q) || (px > xri_q) || (py < yti_q) || (py > ybi_q);
	assign hit     = cmd_q.filled_mode ? in_rect : (in_rect && border);

	assign last_col = ((SW'(c_q) + SW'(1)) == cw);
	assign last_row = ((SW'(r_q) + SW'(1)) == ch);

	assign waddr = AW'(int'(r_q) * MAX_SIDE + int'(c_q));
	assign raddr = AW'(int'(cmd_q.read_row) * MAX_SIDE + int'(cmd_q.read_col));
	assign wdata = (cmd_q.kind == rrc_pkg::KIND_CLEAR) ? bg_char : cmd_q.paint_char;

	always_comb begin
		state_d = state_q;
		case (state_q)
			rrc_pkg::BK_IDLE: begin
				if (!cmd_empty) begin
					case (cmd_head.kind)
						rrc_pkg::KIND_CLEAR: state_d = rrc_pkg::BK_SWEEP;
						rrc_pkg::KIND_DRAW:  state_d = rrc_pkg::BK_SETUP;
						rrc_pkg::KIND_READ:  state_d = rrc_pkg::BK_READ;
						default:             state_d = rrc_pkg::BK_DONE;
					endcase
				end
			end
			rrc_pkg::BK_SETUP: begin
				state_d = rrc_pkg::BK_SWEEP;
			end
			rrc_pkg::BK_SWEEP: begin
				if (last_col && last_row) begin
					state_d = rrc_pkg::BK_DONE;
				end
			end
			rrc_pkg::BK_READ: begin
				state_d = rrc_pkg::BK_DONE;
			end
			rrc_pkg::BK_DONE: begin
				if (!res_full) begin
					state_d = rrc_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = rrc_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_pop            = (state_q == rrc_pkg::BK_IDLE) && !cmd_empty;
		res_push           = (state_q == rrc_pkg::BK_DONE) && !res_full;
		mem_we             = (state_q == rrc_pkg::BK_SWEEP) &&
		                     ((cmd_q.kind == rrc_pkg::KIND_CLEAR) || hit);
		mem_re             = (state_q == rrc_pkg::BK_READ);
		res_data.status    = cmd_q.status;
		res_data.cell_char = (cmd_q.kind == rrc_pkg::KIND_READ) ? rd_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrc_pkg::BK_IDLE;
			c_q     <= '0;
			r_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cmd_pop) begin
				c_q <= '0;
				r_q <= '0;
			end else if (state_q == rrc_pkg::BK_SWEEP) begin
				if (last_col) begin
					c_q <= '0;
					if (!last_row) begin
						r_q <= r_q + 1'b1;
					end
				end else begin
					c_q <= c_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd_head;
		end
		if (state_q == rrc_pkg::BK_SETUP) begin
			xl_q  <= l_ext;
			xr_q  <= l_ext + w_ext;
			xli_q <= l_ext + ONE;
			xri_q <= l_ext + w_ext - ONE;
			yt_q  <= t_ext;
			yb_q  <= t_ext + h_ext;
			yti_q <= t_ext + ONE;
			ybi_q <= t_ext + h_ext - ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cell_mem_q[waddr] <= wdata;
		end
		if (mem_re) begin
			rd_q <= cell_mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sim/tb_rectangle_raster_canvas_core.sv @@
module tb_rectangle_raster_canvas_core;
	import rrc_pkg::*;

	// canvas geometry as the block is built
	localparam int SIDE_MAX = 256;
	localparam int FRAC_W = 8;
	localparam longint FIX_ONE = longint'(1) << FRAC_W;

	// opcode the block has to ignore
	localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

	// a full 256 by 256 sweep covers 65536 cells with nothing moving, so leave ample margin
	localparam int WATCHDOG_LIMIT = 300000;
	localparam int HOLD_OFF_CYCLES = 500;
	localparam int IDLE_PCT = 18;
	localparam int SETTLE_CYCLES = 20;

	// one item as it sits on the input ports
	typedef struct packed {
		logic [OPC_W-1:0]         op;
		logic                     filled;
		logic signed [EDGE_W-1:0] rect_left;
		logic signed [EDGE_W-1:0] rect_top;
		logic [SIZE_W-1:0]        rect_width;
		logic [SIZE_W-1:0]        rect_height;
		logic [CHAR_W-1:0]        paint;
		logic [RC_W-1:0]          read_col;
		logic [RC_W-1:0]          read_row;
	} canvas_cmd_t;

	typedef enum {ZONE_OUT, ZONE_INSIDE, ZONE_BORDER} cell_zone_t;

	// shadow copy of the canvas: registers, cell contents and the replies still owed
	class canvas_shadow;
		logic [CFG_W-1:0]  width_reg;
		logic [CFG_W-1:0]  height_reg;
		logic [CHAR_W-1:0] bg_char;
		logic [CHAR_W-1:0] cells [SIDE_MAX*SIDE_MAX];
		res_t              replies [$];
		int                errors;

		function new();
			width_reg = 1;
			height_reg = 1;
			bg_char = BG_CHAR_RESET;
			errors = 0;
		endfunction

		function int side_in_use(logic [CFG_W-1:0] v);
			if (v == 0)
				return 1;
			if (v > SIDE_MAX)
				return SIDE_MAX;
			return int'(v);
		endfunction

		function void set_register(cfg_reg_t idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_CANVAS_WIDTH:  width_reg = v;
				REG_CANVAS_HEIGHT: height_reg = v;
				REG_BG_CHAR:       bg_char = v[CHAR_W-1:0];
				default: ;
			endcase
		endfunction

		// exact fixed point tests, an edge that passes through a cell keeps it inside
		function cell_zone_t zone_of(longint px, longint py, longint l, longint t,
				longint w, longint h);
			if (px < l || py < t || px > l + w || py > t + h)
				return ZONE_OUT;
			if (px - l < FIX_ONE || py - t < FIX_ONE || l + w - px < FIX_ONE ||
					t + h - py < FIX_ONE)
				return ZONE_BORDER;
			return ZONE_INSIDE;
		endfunction

		// note an accepted input transfer and queue the reply it owes
		function void apply_item(canvas_cmd_t it);
			int cw;
			int ch;
			int col;
			int row;
			longint l;
			longint t;
			longint w;
			longint h;
			cell_zone_t z;
			res_t want;
			cw = side_in_use(width_reg);
			ch = side_in_use(height_reg);
			want.cell_char = '0;
			want.status = ST_OK;
			case (it.op)
				OP_CLEAR: begin
					for (row = 0; row < ch; row++)
						for (col = 0; col < cw; col++)
							cells[row*SIDE_MAX + col] = bg_char;
				end
				OP_DRAW: begin
					l = longint'($signed(it.rect_left));
					t = longint'($signed(it.rect_top));
					w = longint'(it.rect_width);
					h = longint'(it.rect_height);
					if (w < FIX_ONE || h < FIX_ONE) begin
						// too thin: rejected, canvas untouched
						want.status = ST_SMALL;
					end else begin
						for (row = 0; row < ch; row++) begin
							for (col = 0; col < cw; col++) begin
								z = zone_of(longint'(col) << FRAC_W, longint'(row) << FRAC_W,
									l, t, w, h);
								if ((it.filled && z != ZONE_OUT) || (!it.filled && z == ZONE_BORDER))
									cells[row*SIDE_MAX + col] = it.paint;
							end
						end
					end
				end
				OP_READ: begin
					col = int'(it.read_col);
					row = int'(it.read_row);
					if (col >= cw || row >= ch)
						want.status = ST_OUTSIDE;
					else
						want.cell_char = cells[row*SIDE_MAX + col];
				end
				default: ;
			endcase
			replies.push_back(want);
		endfunction

		// check a result transfer against the oldest reply owed
		function void compare_reply(res_t got);
			res_t want;
			if (replies.size() == 0) begin
				$error("result with nothing pending: cell_char %0d status %0d",
					got.cell_char, got.status);
				errors++;
				return;
			end
			want = replies.pop_front();
			if (got.cell_char !== want.cell_char) begin
				$error("cell_char mismatch: expected %0d, actual %0d", want.cell_char, got.cell_char);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status mismatch: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [CFGI_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic push;
	logic full;
	canvas_cmd_t cmd;
	logic empty;
	logic pop;
	logic [CHAR_W-1:0] cell_char;
	logic [ST_W-1:0] status;

	canvas_shadow sb;
	canvas_cmd_t cmd_q [$];
	bit steady;        // no idling on either side while set
	bit hold_off_req;  // asks the receiver for one long stall
	int stall_cycles;

	rectangle_raster_canvas_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.opcode      (cmd.op),
		.filled_mode (cmd.filled),
		.rect_left   (cmd.rect_left),
		.rect_top    (cmd.rect_top),
		.rect_width  (cmd.rect_width),
		.rect_height (cmd.rect_height),
		.paint_char  (cmd.paint),
		.read_col    (cmd.read_col),
		.read_row    (cmd.read_row),
		.empty       (empty),
		.pop         (pop),
		.cell_char   (cell_char),
		.status      (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random pops, plus one long hold-off counted here on request
	always begin
		@(negedge clk);
		if (hold_off_req) begin
			pop = 1'b0;
			repeat (HOLD_OFF_CYCLES) @(negedge clk);
			hold_off_req = 1'b0;
		end
		pop = steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// sample both handshakes at the rising edge, feed the shadow, and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.apply_item(cmd);
			if (pop && !empty)
				sb.compare_reply(res_t'({cell_char, status}));
			if ((push && !full) || (pop && !empty))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("rectangle_raster_canvas_core verification failed");
				$finish;
			end
		end
	end

	// every field random, so unused fields still toggle
	function automatic canvas_cmd_t noise_cmd();
		canvas_cmd_t it;
		it.op = $urandom;
		it.filled = $urandom;
		it.rect_left = $urandom;
		it.rect_top = $urandom;
		it.rect_width = $urandom;
		it.rect_height = $urandom;
		it.paint = $urandom;
		it.read_col = $urandom;
		it.read_row = $urandom;
		return it;
	endfunction

	function automatic canvas_cmd_t clear_cmd();
		canvas_cmd_t it;
		it = noise_cmd();
		it.op = OP_CLEAR;
		return it;
	endfunction

	function automatic canvas_cmd_t unknown_cmd();
		canvas_cmd_t it;
		it = noise_cmd();
		it.op = OP_UNUSED;
		return it;
	endfunction

	// positions and sizes are in 1/256 of a cell
	function automatic canvas_cmd_t draw_cmd(bit filled, int l, int t, int w, int h, int pc);
		canvas_cmd_t it;
		it = noise_cmd();
		it.op = OP_DRAW;
		it.filled = filled;
		it.rect_left = l;
		it.rect_top = t;
		it.rect_width = w;
		it.rect_height = h;
		it.paint = pc;
		return it;
	endfunction

	function automatic canvas_cmd_t read_cmd(int col, int row);
		canvas_cmd_t it;
		it = noise_cmd();
		it.op = OP_READ;
		it.read_col = col;
		it.read_row = row;
		return it;
	endfunction

	// random item shaped for a cw by ch canvas; every phase starts with a clear,
	// so any cell inside the canvas has been written before it can be read
	function automatic canvas_cmd_t rand_item(int cw, int ch);
		canvas_cmd_t it;
		int pick;
		it = noise_cmd();
		pick = $urandom_range(99);
		if (pick < 8) begin
			it.op = OP_CLEAR;
		end else if (pick < 45) begin
			it.op = OP_DRAW;
			// one in ten keeps the raw random geometry, far off the canvas as a rule
			if ($urandom_range(9) != 0) begin
				it.rect_left = $urandom_range(0, (cw + 4) * 256) - 512;
				it.rect_top = $urandom_range(0, (ch + 4) * 256) - 512;
				it.rect_width = $urandom_range(0, (cw + 2) * 256);
				it.rect_height = $urandom_range(0, (ch + 2) * 256);
				// whole-cell geometry puts edges exactly on cells
				if ($urandom_range(2) == 0) begin
					it.rect_left[FRAC_W-1:0] = '0;
					it.rect_top[FRAC_W-1:0] = '0;
					it.rect_width[FRAC_W-1:0] = '0;
					it.rect_height[FRAC_W-1:0] = '0;
				end
			end
		end else if (pick < 95) begin
			it.op = OP_READ;
			if ($urandom_range(4) != 0) begin
				it.read_col = $urandom_range(0, cw - 1);
				it.read_row = $urandom_range(0, ch - 1);
			end
		end else begin
			it.op = OP_UNUSED;
		end
		return it;
	endfunction

	// offer every queued item, idling at random between transfers
	task automatic send_queue();
		canvas_cmd_t it;
		while (cmd_q.size() > 0) begin
			it = cmd_q.pop_front();
			@(negedge clk);
			while (!steady && $urandom_range(99) < IDLE_PCT) begin
				push = 1'b0;
				@(negedge clk);
			end
			cmd = it;
			push = 1'b1;
			@(posedge clk);
			while (full)
				@(posedge clk);
		end
		@(negedge clk);
		push = 1'b0;
	endtask

	// every item owes exactly one reply, so an empty queue means the block is idle
	task automatic wait_drained();
		while (sb.replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// all three registers, one per cycle, only while idle
	task automatic set_canvas(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [CHAR_W-1:0] bg);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = REG_CANVAS_WIDTH;
		cfg_data = w;
		sb.set_register(REG_CANVAS_WIDTH, w);
		@(negedge clk);
		cfg_index = REG_CANVAS_HEIGHT;
		cfg_data = h;
		sb.set_register(REG_CANVAS_HEIGHT, h);
		@(negedge clk);
		cfg_index = REG_BG_CHAR;
		cfg_data = {1'b0, bg};
		sb.set_register(REG_BG_CHAR, {1'b0, bg});
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_CANVAS_WIDTH;
		cfg_data = '0;
		push = 1'b0;
		pop = 1'b0;
		cmd = '0;
		steady = 1'b0;
		hold_off_req = 1'b0;
		stall_cycles = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// smallest canvas, background zero
		set_canvas(1, 1, 8'd0);
		cmd_q.push_back(clear_cmd());
		cmd_q.push_back(read_cmd(0, 0));
		cmd_q.push_back(read_cmd(1, 0));
		cmd_q.push_back(read_cmd(0, 1));
		cmd_q.push_back(read_cmd(255, 255));
		// one-by-one rectangle on the only cell: border, painted in either mode
		cmd_q.push_back(draw_cmd(1, 0, 0, 256, 256, 255));
		cmd_q.push_back(read_cmd(0, 0));
		// just under one cell wide, then zero high: both rejected
		cmd_q.push_back(draw_cmd(1, 0, 0, 255, 256, 1));
		cmd_q.push_back(draw_cmd(0, 0, 0, 256, 0, 2));
		cmd_q.push_back(unknown_cmd());
		// cell two away from every edge: inside, so outline skips it and filled paints it
		cmd_q.push_back(draw_cmd(0, -512, -512, 1024, 1024, 8'h55));
		cmd_q.push_back(read_cmd(0, 0));
		cmd_q.push_back(draw_cmd(1, -512, -512, 1024, 1024, 8'haa));
		cmd_q.push_back(read_cmd(0, 0));
		send_queue();
		wait_drained();

		// mid-size canvas: directed edge cases, then the bulk of the random items
		set_canvas(16, 12, $urandom_range(255));
		cmd_q.push_back(clear_cmd());
		// outline with edges on whole cells
		cmd_q.push_back(draw_cmd(0, 2 * 256, 3 * 256, 4 * 256, 3 * 256, 8'h23));
		cmd_q.push_back(read_cmd(2, 3));
		cmd_q.push_back(read_cmd(3, 4));
		cmd_q.push_back(read_cmd(6, 6));
		cmd_q.push_back(read_cmd(4, 6));
		cmd_q.push_back(read_cmd(7, 3));
		// fractional origin, widest possible rectangle
		cmd_q.push_back(draw_cmd(1, -128, 2752, 524287, 256, 8'h7e));
		cmd_q.push_back(read_cmd(0, 11));
		cmd_q.push_back(read_cmd(15, 11));
		// most negative and most positive origins: nothing lands on the canvas
		cmd_q.push_back(draw_cmd(1, -524288, -524288, 524287, 524287, 8'h01));
		cmd_q.push_back(draw_cmd(1, 524287, 524287, 524287, 524287, 8'h02));
		cmd_q.push_back(read_cmd(15, 11));
		cmd_q.push_back(read_cmd(0, 0));
		send_queue();

		// receiver stalls for a long while as the sender keeps offering, so input backs up
		hold_off_req = 1'b1;
		repeat (15) cmd_q.push_back(rand_item(16, 12));
		send_queue();
		// sender pauses until every reply is back
		wait_drained();
		steady = 1'b1;
		repeat (15) cmd_q.push_back(rand_item(16, 12));
		send_queue();
		steady = 1'b0;
		wait_drained();

		// largest canvas: only a handful of sweeps, each one covers 65536 cells
		set_canvas(256, 256, 8'd255);
		cmd_q.push_back(clear_cmd());
		cmd_q.push_back(draw_cmd(1, 2688, -832, 51392, 25600, 8'h41));
		cmd_q.push_back(draw_cmd(0, -256, -256, 257 * 256, 257 * 256, 8'h42));
		cmd_q.push_back(draw_cmd(1, 0, 0, 100, 524287, 8'h43));
		cmd_q.push_back(read_cmd(255, 255));
		cmd_q.push_back(read_cmd(255, 0));
		cmd_q.push_back(read_cmd(0, 255));
		cmd_q.push_back(read_cmd(20, 10));
		cmd_q.push_back(read_cmd(128, 50));
		repeat (6) cmd_q.push_back(read_cmd($urandom_range(255), $urandom_range(255)));
		cmd_q.push_back(unknown_cmd());
		send_queue();
		wait_drained();

		// width zero and height past the maximum clamp to a 1 by 256 column
		set_canvas(0, 511, 8'd255);
		cmd_q.push_back(clear_cmd());
		cmd_q.push_back(draw_cmd(0, -128, 25664, 256, 12800, 8'h5a));
		cmd_q.push_back(read_cmd(0, 255));
		cmd_q.push_back(read_cmd(1, 100));
		cmd_q.push_back(read_cmd(0, 100));
		repeat (10) cmd_q.push_back(rand_item(1, 256));
		send_queue();
		wait_drained();

		// odd-sized canvas to finish
		set_canvas(9, 7, $urandom_range(255));
		cmd_q.push_back(clear_cmd());
		repeat (10) cmd_q.push_back(rand_item(9, 7));
		send_queue();
		wait_drained();

		if (sb.errors == 0)
			$display("rectangle_raster_canvas_core verification clean");
		else
			$display("rectangle_raster_canvas_core verification failed");
		$finish;
	end

endmodule

@@ rectangle_raster_canvas_core.f @@
+incdir+rtl
rtl/rrc_pkg.sv
rtl/rrc_fifo.sv
rtl/rrc_front.sv
rtl/rrc_back.sv
rtl/rectangle_raster_canvas_core.sv
sim/tb_rectangle_raster_canvas_core.sv
